### hdl/svm_pkg.sv
// svm_pkg: shared types, codes and constants of the sample voice mixer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

    localparam int VOICE_SLOTS_DEF  = 32;
    localparam int SAMPLE_WORDS_DEF = 16384;
    localparam int CLIP_ENTRIES_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 5;
    localparam int ADDR_W   = 14;
    localparam int SMP_W    = 16;
    localparam int FRAMES_W = 15;
    localparam int BUS_W    = 2;
    localparam int STEP_W   = 19;
    localparam int GAIN_W   = 16;
    localparam int CNT_W    = 6;
    localparam int CUR_W    = 32;
    localparam int MUTE_W   = 4;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [15:0] GAIN_UNITY = 16'd32768;

    // tanh table seed: exp(-1/8) and one, both Q30
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] EXP_STEP_Q30 = 64'd947573834;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_PAUSE    = 3'd3,
        CMD_RESUME   = 3'd4,
        CMD_STOP_ALL = 3'd5,
        CMD_RENDER   = 3'd6,
        CMD_UPDATE   = 3'd7
    } cmd_e_t;

    typedef enum logic [2:0] {
        REG_MASTER = 3'd0,
        REG_SFX    = 3'd1,
        REG_MUSIC  = 3'd2,
        REG_SPEECH = 3'd3,
        REG_MUTE   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RFETCH,
        ST_RCHECK,
        ST_RWRAP,
        ST_RADDR0,
        ST_RADDR1,
        ST_RMUL,
        ST_RGAIN,
        ST_RSCALE,
        ST_RACC,
        ST_RCLIP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [15:0]       master_gain;
        logic [15:0]       sfx_gain;
        logic [15:0]       music_gain;
        logic [15:0]       speech_gain;
        logic [MUTE_W-1:0] mute_mask;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic voice_rd;
        logic check;
        logic wrap_step;
        logic finish;
        logic advance;
        logic smp_rd0;
        logic smp_rd1;
        logic mul;
        logic gain;
        logic scale;
        logic accum;
        logic clip;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_e_t cmd;
        logic   vskip;
        logic   vfinish;
        logic   vwrap;
        logic   wrap_last;
        logic   last_voice;
        logic   out_free;
    } dp_status_t;

    // Q30 power exp(-(16+n)/8), rounded half up after every product
    function automatic logic [63:0] clip_pow(input int n);
        logic [63:0] p;
        p = ONE_Q30;
        for (int i = 0; i < 16 + n; i++) begin
            p = (p * EXP_STEP_Q30 + (ONE_Q30 >> 1)) >> 30;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

### hdl/svm_ctrl.sv
// svm_ctrl: sequencer of the mixer; walks commands and the per-voice render steps.
// Depends on svm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire svm_pkg::dp_status_t   st,
    output svm_pkg::ctrl_cmd_t         cmd
);

    svm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= svm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            svm_pkg::ST_IDLE: begin
                if (s_valid) state_next = svm_pkg::ST_EXEC;
            end
            svm_pkg::ST_EXEC: begin
                if (st.cmd == svm_pkg::CMD_RENDER) state_next = svm_pkg::ST_RFETCH;
                else state_next = svm_pkg::ST_RESP;
            end
            svm_pkg::ST_RFETCH: state_next = svm_pkg::ST_RCHECK;
            svm_pkg::ST_RCHECK: begin
                if (st.vskip || st.vfinish) begin
                    state_next = st.last_voice ? svm_pkg::ST_RCLIP : svm_pkg::ST_RFETCH;
                end else if (st.vwrap) begin
                    state_next = svm_pkg::ST_RWRAP;
                end else begin
                    state_next = svm_pkg::ST_RADDR0;
                end
            end
            svm_pkg::ST_RWRAP: begin
                if (st.wrap_last) state_next = svm_pkg::ST_RADDR0;
            end
            svm_pkg::ST_RADDR0: state_next = svm_pkg::ST_RADDR1;
            svm_pkg::ST_RADDR1: state_next = svm_pkg::ST_RMUL;
            svm_pkg::ST_RMUL:   state_next = svm_pkg::ST_RGAIN;
            svm_pkg::ST_RGAIN:  state_next = svm_pkg::ST_RSCALE;
            svm_pkg::ST_RSCALE: state_next = svm_pkg::ST_RACC;
            svm_pkg::ST_RACC: begin
                state_next = st.last_voice ? svm_pkg::ST_RCLIP : svm_pkg::ST_RFETCH;
            end
            svm_pkg::ST_RCLIP: state_next = svm_pkg::ST_RESP;
            svm_pkg::ST_RESP: begin
                if (st.out_free) state_next = svm_pkg::ST_IDLE;
            end
            default: state_next = svm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            svm_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            svm_pkg::ST_EXEC:   cmd.exec = (st.cmd != svm_pkg::CMD_RENDER);
            svm_pkg::ST_RFETCH: cmd.voice_rd = 1'b1;
            svm_pkg::ST_RCHECK: begin
                cmd.check   = 1'b1;
                cmd.finish  = st.vfinish;
                cmd.advance = st.vskip || st.vfinish;
            end
            svm_pkg::ST_RWRAP:  cmd.wrap_step = 1'b1;
            svm_pkg::ST_RADDR0: cmd.smp_rd0 = 1'b1;
            svm_pkg::ST_RADDR1: cmd.smp_rd1 = 1'b1;
            svm_pkg::ST_RMUL:   cmd.mul = 1'b1;
            svm_pkg::ST_RGAIN:  cmd.gain = 1'b1;
            svm_pkg::ST_RSCALE: cmd.scale = 1'b1;
            svm_pkg::ST_RACC: begin
                cmd.accum   = 1'b1;
                cmd.advance = 1'b1;
            end
            svm_pkg::ST_RCLIP:  cmd.clip = 1'b1;
            svm_pkg::ST_RESP:   cmd.out_load = st.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### hdl/svm_datapath.sv
// svm_datapath: sample store, voice table, interpolation, gain, mix and soft clip.
// Depends on svm_pkg; driven by svm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module svm_datapath #(
    parameter int VOICE_SLOTS        = svm_pkg::VOICE_SLOTS_DEF,
    parameter int SAMPLE_WORDS       = svm_pkg::SAMPLE_WORDS_DEF,
    parameter int CLIP_TABLE_ENTRIES = svm_pkg::CLIP_ENTRIES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire svm_pkg::ctrl_cmd_t                    cmd,
    output svm_pkg::dp_status_t                        st,
    input  wire svm_pkg::cfg_t                         cfg,
    input  wire logic [svm_pkg::CMD_W-1:0]             s_command,
    input  wire logic [svm_pkg::SLOT_W-1:0]            s_voice_slot,
    input  wire logic [svm_pkg::ADDR_W-1:0]            s_address,
    input  wire logic signed [svm_pkg::SMP_W-1:0]      s_sample_left,
    input  wire logic signed [svm_pkg::SMP_W-1:0]      s_sample_right,
    input  wire logic [svm_pkg::FRAMES_W-1:0]          s_clip_frames,
    input  wire logic                                  s_looping,
    input  wire logic [svm_pkg::BUS_W-1:0]             s_bus,
    input  wire logic [svm_pkg::STEP_W-1:0]            s_step,
    input  wire logic [svm_pkg::GAIN_W-1:0]            s_gain_left,
    input  wire logic [svm_pkg::GAIN_W-1:0]            s_gain_right,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_frame_valid,
    output logic signed [svm_pkg::SMP_W-1:0]           m_out_left,
    output logic signed [svm_pkg::SMP_W-1:0]           m_out_right,
    output logic [svm_pkg::CNT_W-1:0]                  m_active_count,
    output logic                                       m_slot_playing
);

    localparam int VS_AW     = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int SW_AW     = $clog2(SAMPLE_WORDS);
    localparam int CT_AW     = $clog2(CLIP_TABLE_ENTRIES);
    localparam int ACC_W     = 24 + VS_AW;
    localparam int MOD_STEPS = (SAMPLE_WORDS >= (1 << 17)) ? 1
                               : $clog2((1 << 17) / SAMPLE_WORDS) + 1;

    // reduce a frame address modulo the store depth, one compare-subtract per bit
    function automatic logic [SW_AW-1:0] wrap_addr(input logic [16:0] x);
        logic [31:0] r;
        r = 32'(x);
        for (int j = MOD_STEPS - 1; j >= 0; j--) begin
            if (r >= (32'(SAMPLE_WORDS) << j)) r = r - (32'(SAMPLE_WORDS) << j);
        end
        return r[SW_AW-1:0];
    endfunction

    function automatic logic [CT_AW-1:0] clip_index(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] k;
        m = (a < 0) ? ACC_W'(-a) : ACC_W'(a);
        k = (m - ACC_W'(32768)) >> 11;
        if (k > ACC_W'(CLIP_TABLE_ENTRIES - 1)) return CT_AW'(CLIP_TABLE_ENTRIES - 1);
        return k[CT_AW-1:0];
    endfunction

    // tanh(1 + k/16) table, settled at elaboration
    logic [15:0] clip_rom [CLIP_TABLE_ENTRIES];
    for (genvar k = 0; k < CLIP_TABLE_ENTRIES; k++) begin : g_clip
        localparam logic [63:0] P = svm_pkg::clip_pow(k);
        localparam logic [63:0] T = ((svm_pkg::ONE_Q30 - P) * 64'd32768
                                    + ((svm_pkg::ONE_Q30 + P) >> 1))
                                    / (svm_pkg::ONE_Q30 + P);
        assign clip_rom[k] = (T > 64'd32767) ? 16'd32767 : T[15:0];
    end

    // captured item
    svm_pkg::cmd_e_t                  in_cmd_reg;
    logic [svm_pkg::SLOT_W-1:0]       in_slot_reg;
    logic [svm_pkg::ADDR_W-1:0]       in_addr_reg;
    logic [2*svm_pkg::SMP_W-1:0]      in_smp_reg;
    logic [svm_pkg::FRAMES_W-1:0]     in_frames_reg;
    logic                             in_loop_reg;
    logic [svm_pkg::BUS_W-1:0]        in_bus_reg;
    logic [svm_pkg::STEP_W-1:0]       in_step_reg;
    logic [2*svm_pkg::GAIN_W-1:0]     in_gains_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg    <= svm_pkg::cmd_e_t'(s_command);
            in_slot_reg   <= s_voice_slot;
            in_addr_reg   <= s_address;
            in_smp_reg    <= {s_sample_left, s_sample_right};
            in_frames_reg <= s_clip_frames;
            in_loop_reg   <= s_looping;
            in_bus_reg    <= s_bus;
            in_step_reg   <= s_step;
            in_gains_reg  <= {s_gain_left, s_gain_right};
        end
    end

    logic             slot_ok;
    logic [VS_AW-1:0] slot_idx;
    assign slot_ok  = (32'(in_slot_reg) < VOICE_SLOTS);
    assign slot_idx = VS_AW'(in_slot_reg);

    logic is_start, is_update;
    assign is_start  = cmd.exec && slot_ok && (in_cmd_reg == svm_pkg::CMD_START);
    assign is_update = cmd.exec && slot_ok && (in_cmd_reg == svm_pkg::CMD_UPDATE);

    // render voice index
    logic [VS_AW-1:0] v_reg, v_next;
    always_comb begin
        v_next = v_reg;
        if (cmd.capture) v_next = '0;
        else if (cmd.advance) v_next = v_reg + VS_AW'(1);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else v_reg <= v_next;
    end

    // voice flags and active count
    logic [VOICE_SLOTS-1:0]     act_reg, pause_reg, loop_reg;
    logic [svm_pkg::CNT_W-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= '0;
            pause_reg <= '0;
            loop_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.exec && slot_ok) begin
                case (in_cmd_reg)
                    svm_pkg::CMD_START: begin
                        act_reg[slot_idx]   <= 1'b1;
                        pause_reg[slot_idx] <= 1'b0;
                        loop_reg[slot_idx]  <= in_loop_reg;
                        if (!act_reg[slot_idx]) count_reg <= count_reg + 1'b1;
                    end
                    svm_pkg::CMD_STOP: begin
                        act_reg[slot_idx] <= 1'b0;
                        if (act_reg[slot_idx]) count_reg <= count_reg - 1'b1;
                    end
                    svm_pkg::CMD_PAUSE:  pause_reg[slot_idx] <= 1'b1;
                    svm_pkg::CMD_RESUME: pause_reg[slot_idx] <= 1'b0;
                    svm_pkg::CMD_UPDATE: loop_reg[slot_idx]  <= in_loop_reg;
                    default: ;
                endcase
            end
            if (cmd.exec && in_cmd_reg == svm_pkg::CMD_STOP_ALL) begin
                act_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.finish) begin
                act_reg[v_reg] <= 1'b0;
                count_reg      <= count_reg - 1'b1;
            end
        end
    end

    // voice table memories, read at the render index
    logic [svm_pkg::ADDR_W-1:0]   base_mem  [VOICE_SLOTS];
    logic [svm_pkg::FRAMES_W-1:0] len_mem   [VOICE_SLOTS];
    logic [svm_pkg::CUR_W-1:0]    cur_mem   [VOICE_SLOTS];
    logic [svm_pkg::STEP_W-1:0]   step_mem  [VOICE_SLOTS];
    logic [2*svm_pkg::GAIN_W-1:0] gains_mem [VOICE_SLOTS];
    logic [svm_pkg::BUS_W-1:0]    bus_mem   [VOICE_SLOTS];

    logic [svm_pkg::ADDR_W-1:0]   base_rd;
    logic [svm_pkg::FRAMES_W-1:0] len_rd;
    logic [svm_pkg::CUR_W-1:0]    cur_rd;
    logic [svm_pkg::STEP_W-1:0]   step_rd;
    logic [2*svm_pkg::GAIN_W-1:0] gains_rd;
    logic [svm_pkg::BUS_W-1:0]    bus_rd;

    logic [svm_pkg::CUR_W-1:0] cur_reg;
    logic                      cur_we;
    logic [VS_AW-1:0]          cur_wa;
    logic [svm_pkg::CUR_W-1:0] cur_wd;

    assign cur_we = is_start || cmd.accum;
    assign cur_wa = cmd.accum ? v_reg : slot_idx;
    assign cur_wd = cmd.accum ? (cur_reg + svm_pkg::CUR_W'(step_rd)) : '0;

    always_ff @(posedge aclk) begin
        if (is_start) begin
            base_mem[slot_idx] <= in_addr_reg;
            len_mem[slot_idx]  <= in_frames_reg;
        end
        if (cmd.voice_rd) begin
            base_rd <= base_mem[v_reg];
            len_rd  <= len_mem[v_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cur_we) cur_mem[cur_wa] <= cur_wd;
        if (cmd.voice_rd) cur_rd <= cur_mem[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (is_start || is_update) begin
            step_mem[slot_idx]  <= in_step_reg;
            gains_mem[slot_idx] <= in_gains_reg;
            bus_mem[slot_idx]   <= in_bus_reg;
        end
        if (cmd.voice_rd) begin
            step_rd  <= step_mem[v_reg];
            gains_rd <= gains_mem[v_reg];
            bus_rd   <= bus_mem[v_reg];
        end
    end

    // per-voice checks
    logic v_run, past_end;
    assign v_run    = act_reg[v_reg] && !pause_reg[v_reg];
    assign past_end = (cur_rd[31:16] >= {1'b0, len_rd});

    // cursor wrap: restoring remainder of the frame index, one bit a cycle
    logic [15:0] rem_reg, rem_shift, rem_new;
    logic [3:0]  wrap_cnt_reg;

    always_comb begin
        rem_shift = {rem_reg[14:0], cur_reg[5'd31 - 5'(wrap_cnt_reg)]};
        rem_new   = (rem_shift >= {1'b0, len_rd}) ? rem_shift - {1'b0, len_rd} : rem_shift;
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            cur_reg      <= cur_rd;
            rem_reg      <= '0;
            wrap_cnt_reg <= '0;
        end else if (cmd.wrap_step) begin
            rem_reg      <= rem_new;
            wrap_cnt_reg <= wrap_cnt_reg + 4'd1;
            if (wrap_cnt_reg == 4'd15) cur_reg <= {rem_new, cur_reg[15:0]};
        end
    end

    // sample store
    logic [2*svm_pkg::SMP_W-1:0] smp_mem [SAMPLE_WORDS];
    logic [2*svm_pkg::SMP_W-1:0] smp_rd, w0_reg;
    logic [15:0] ip, nx;
    logic [16:0] ip1;
    logic [SW_AW-1:0] smp_ra;
    logic load_we;

    assign ip      = cur_reg[31:16];
    assign ip1     = {1'b0, ip} + 17'd1;
    assign nx      = (ip1 >= {2'b0, len_rd}) ? (loop_reg[v_reg] ? 16'd0 : ip) : ip1[15:0];
    assign smp_ra  = wrap_addr({3'b0, base_rd} + {1'b0, (cmd.smp_rd1 ? nx : ip)});
    assign load_we = cmd.exec && (in_cmd_reg == svm_pkg::CMD_LOAD);

    always_ff @(posedge aclk) begin
        if (load_we) smp_mem[wrap_addr({3'b0, in_addr_reg})] <= in_smp_reg;
        if (cmd.smp_rd0 || cmd.smp_rd1) smp_rd <= smp_mem[smp_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.smp_rd1) w0_reg <= smp_rd;
    end

    // gains
    logic [15:0] bus_gain, master_eff;
    always_comb begin
        case (bus_rd)
            2'd0:    bus_gain = cfg.master_gain;
            2'd1:    bus_gain = cfg.sfx_gain;
            2'd2:    bus_gain = cfg.music_gain;
            default: bus_gain = cfg.speech_gain;
        endcase
        if (cfg.mute_mask[bus_rd]) bus_gain = '0;
        master_eff = cfg.mute_mask[0] ? 16'd0 : cfg.master_gain;
    end

    // arithmetic stages: two multiplies per lane in the mul stage, one in the gain and scale stages
    logic signed [16:0] d_l, d_r;
    logic signed [33:0] prod_l_reg, prod_r_reg;
    logic [31:0]        g1p_l_reg, g1p_r_reg;
    logic [17:0]        g1_l, g1_r;
    logic signed [16:0] s_l_reg, s_r_reg;
    logic [33:0]        g2p_l_reg, g2p_r_reg;
    logic [19:0]        g2_l, g2_r;
    logic signed [37:0] sp_l_reg, sp_r_reg;
    logic signed [38:0] spr_l, spr_r;
    logic signed [23:0] contrib_l, contrib_r;
    logic signed [17:0] s_sum_l, s_sum_r;

    assign d_l = 17'(signed'(smp_rd[31:16])) - 17'(signed'(w0_reg[31:16]));
    assign d_r = 17'(signed'(smp_rd[15:0]))  - 17'(signed'(w0_reg[15:0]));

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_l_reg <= $signed({1'b0, cur_reg[15:0]}) * d_l;
            prod_r_reg <= $signed({1'b0, cur_reg[15:0]}) * d_r;
            g1p_l_reg  <= gains_rd[31:16] * bus_gain;
            g1p_r_reg  <= gains_rd[15:0] * bus_gain;
        end
    end

    assign g1_l    = 18'(({1'b0, g1p_l_reg} + 33'd16384) >> 15);
    assign g1_r    = 18'(({1'b0, g1p_r_reg} + 33'd16384) >> 15);
    assign s_sum_l = 18'(signed'(w0_reg[31:16])) + prod_l_reg[33:16];
    assign s_sum_r = 18'(signed'(w0_reg[15:0]))  + prod_r_reg[33:16];

    always_ff @(posedge aclk) begin
        if (cmd.gain) begin
            s_l_reg   <= s_sum_l[16:0];
            s_r_reg   <= s_sum_r[16:0];
            g2p_l_reg <= g1_l * master_eff;
            g2p_r_reg <= g1_r * master_eff;
        end
    end

    assign g2_l = 20'(({1'b0, g2p_l_reg} + 35'd16384) >> 15);
    assign g2_r = 20'(({1'b0, g2p_r_reg} + 35'd16384) >> 15);

    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            sp_l_reg <= s_l_reg * $signed({1'b0, g2_l});
            sp_r_reg <= s_r_reg * $signed({1'b0, g2_r});
        end
    end

    assign spr_l     = 39'(sp_l_reg) + 39'sd16384;
    assign spr_r     = 39'(sp_r_reg) + 39'sd16384;
    assign contrib_l = 24'(spr_l >>> 15);
    assign contrib_r = 24'(spr_r >>> 15);

    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (cmd.accum) begin
            acc_l_reg <= acc_l_reg + ACC_W'(contrib_l);
            acc_r_reg <= acc_r_reg + ACC_W'(contrib_r);
        end
    end

    // soft clip beyond full scale
    logic signed [15:0] clip_l, clip_r;
    logic [15:0]        t_l, t_r;
    always_comb begin
        t_l = clip_rom[clip_index(acc_l_reg)];
        t_r = clip_rom[clip_index(acc_r_reg)];
        if (acc_l_reg > 32767)       clip_l = signed'(t_l);
        else if (acc_l_reg < -32768) clip_l = -signed'(t_l);
        else                         clip_l = acc_l_reg[15:0];
        if (acc_r_reg > 32767)       clip_r = signed'(t_r);
        else if (acc_r_reg < -32768) clip_r = -signed'(t_r);
        else                         clip_r = acc_r_reg[15:0];
    end

    logic signed [15:0] res_l_reg, res_r_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_l_reg <= '0;
            res_r_reg <= '0;
        end else if (cmd.clip) begin
            res_l_reg <= clip_l;
            res_r_reg <= clip_r;
        end
    end

    // output register
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_frame_valid  <= (in_cmd_reg == svm_pkg::CMD_RENDER);
            m_out_left     <= res_l_reg;
            m_out_right    <= res_r_reg;
            m_active_count <= count_reg;
            m_slot_playing <= slot_ok && act_reg[slot_idx] && !pause_reg[slot_idx];
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        st            = '0;
        st.cmd        = in_cmd_reg;
        st.vskip      = !v_run;
        st.vfinish    = v_run && ((len_rd == '0) || (past_end && !loop_reg[v_reg]));
        st.vwrap      = v_run && (len_rd != '0) && past_end && loop_reg[v_reg];
        st.wrap_last  = (wrap_cnt_reg == 4'd15);
        st.last_voice = (32'(v_reg) == VOICE_SLOTS - 1);
        st.out_free   = !m_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

### hdl/sample_voice_mixer_core.sv
// Control and load items go from capture through execution to the response state. A render
// item walks every voice slot; each playing voice is fetched, checked, read twice from the sample
// store, multiplied, gained, scaled and accumulated; a looping voice past its end wraps first.
// One item in work at a time; a held result stalls the next item in its response state.
// Reset (aresetn, synchronous, low): slots free, gains 32768, mute mask clear;
// sample store and voice fields hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module sample_voice_mixer_core #(
    parameter int VOICE_SLOTS        = svm_pkg::VOICE_SLOTS_DEF,
    parameter int SAMPLE_WORDS       = svm_pkg::SAMPLE_WORDS_DEF,
    parameter int CLIP_TABLE_ENTRIES = svm_pkg::CLIP_ENTRIES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration, APB style
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [svm_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [svm_pkg::PDATA_W-1:0]           pwdata,
    output logic [svm_pkg::PDATA_W-1:0]                prdata,
    output logic                                       pready,
    // command items
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [svm_pkg::CMD_W-1:0]             s_command,
    input  wire logic [svm_pkg::SLOT_W-1:0]            s_voice_slot,
    input  wire logic [svm_pkg::ADDR_W-1:0]            s_address,
    input  wire logic signed [svm_pkg::SMP_W-1:0]      s_sample_left,
    input  wire logic signed [svm_pkg::SMP_W-1:0]      s_sample_right,
    input  wire logic [svm_pkg::FRAMES_W-1:0]          s_clip_frames,
    input  wire logic                                  s_looping,
    input  wire logic [svm_pkg::BUS_W-1:0]             s_bus,
    input  wire logic [svm_pkg::STEP_W-1:0]            s_step,
    input  wire logic [svm_pkg::GAIN_W-1:0]            s_gain_left,
    input  wire logic [svm_pkg::GAIN_W-1:0]            s_gain_right,
    // result items
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_frame_valid,
    output logic signed [svm_pkg::SMP_W-1:0]           m_out_left,
    output logic signed [svm_pkg::SMP_W-1:0]           m_out_right,
    output logic [svm_pkg::CNT_W-1:0]                  m_active_count,
    output logic                                       m_slot_playing
);

    // register file: word index from paddr[4:2], writes in the access phase
    svm_pkg::cfg_t     cfg_reg;
    svm_pkg::reg_idx_t reg_idx;
    logic              cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = svm_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_gain <= svm_pkg::GAIN_UNITY;
            cfg_reg.sfx_gain    <= svm_pkg::GAIN_UNITY;
            cfg_reg.music_gain  <= svm_pkg::GAIN_UNITY;
            cfg_reg.speech_gain <= svm_pkg::GAIN_UNITY;
            cfg_reg.mute_mask   <= '0;
        end else if (cfg_we) begin
            case (reg_idx)
                svm_pkg::REG_MASTER: cfg_reg.master_gain <= pwdata[15:0];
                svm_pkg::REG_SFX:    cfg_reg.sfx_gain    <= pwdata[15:0];
                svm_pkg::REG_MUSIC:  cfg_reg.music_gain  <= pwdata[15:0];
                svm_pkg::REG_SPEECH: cfg_reg.speech_gain <= pwdata[15:0];
                svm_pkg::REG_MUTE:   cfg_reg.mute_mask   <= pwdata[svm_pkg::MUTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            svm_pkg::REG_MASTER: prdata = 32'(cfg_reg.master_gain);
            svm_pkg::REG_SFX:    prdata = 32'(cfg_reg.sfx_gain);
            svm_pkg::REG_MUSIC:  prdata = 32'(cfg_reg.music_gain);
            svm_pkg::REG_SPEECH: prdata = 32'(cfg_reg.speech_gain);
            svm_pkg::REG_MUTE:   prdata = 32'(cfg_reg.mute_mask);
            default:             prdata = '0;
        endcase
    end

    // sequencer and datapath talk through one command and one status bundle
    svm_pkg::ctrl_cmd_t  cmd;
    svm_pkg::dp_status_t st;

    svm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    svm_datapath #(
        .VOICE_SLOTS        (VOICE_SLOTS),
        .SAMPLE_WORDS       (SAMPLE_WORDS),
        .CLIP_TABLE_ENTRIES (CLIP_TABLE_ENTRIES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg            (cfg_reg),
        .s_command      (s_command),
        .s_voice_slot   (s_voice_slot),
        .s_address      (s_address),
        .s_sample_left  (s_sample_left),
        .s_sample_right (s_sample_right),
        .s_clip_frames  (s_clip_frames),
        .s_looping      (s_looping),
        .s_bus          (s_bus),
        .s_step         (s_step),
        .s_gain_left    (s_gain_left),
        .s_gain_right   (s_gain_right),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_valid  (m_frame_valid),
        .m_out_left     (m_out_left),
        .m_out_right    (m_out_right),
        .m_active_count (m_active_count),
        .m_slot_playing (m_slot_playing)
    );

endmodule
`default_nettype wire

### hdl/svm_checker.sv
// svm_checker: port-level checks of the mixer, bound to the top level.
// Depends on svm_pkg and sample_voice_mixer_core.
`timescale 1ns / 1ps
`default_nettype none
module svm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic                             m_frame_valid,
    input wire logic signed [svm_pkg::SMP_W-1:0] m_out_left,
    input wire logic signed [svm_pkg::SMP_W-1:0] m_out_right,
    input wire logic [svm_pkg::CNT_W-1:0]        m_active_count,
    input wire logic                             m_slot_playing
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left) && $stable(m_active_count))
        else $error("result item changed while stalled");

    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_valid |-> m_out_left == 0 && m_out_right == 0)
        else $error("non-render item carries samples");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_active_count <= 6'd32 && (!m_slot_playing || m_active_count != 0))
        else $error("active count inconsistent");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item in work at a time: input closes right after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in work");

endmodule

bind sample_voice_mixer_core svm_checker u_svm_checker (.*);
`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking bench for sample_voice_mixer_core (valid/ready items, APB config).
// Depends on svm_pkg and the core; a bit-true mixer model predicts each result item.
`timescale 1ns / 1ps
module tb_top;

    localparam int NSLOT = 32;
    localparam int NWORD = 16384;
    localparam int NCLIP = 64;
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned Q30_DECAY = 64'd947573834;   // exp(-1/8)
    localparam int ITEM_TARGET = 1600;

    localparam int CMD_W    = svm_pkg::CMD_W;
    localparam int SLOT_W   = svm_pkg::SLOT_W;
    localparam int ADDR_W   = svm_pkg::ADDR_W;
    localparam int SMP_W    = svm_pkg::SMP_W;
    localparam int FRAMES_W = svm_pkg::FRAMES_W;
    localparam int BUS_W    = svm_pkg::BUS_W;
    localparam int STEP_W   = svm_pkg::STEP_W;
    localparam int GAIN_W   = svm_pkg::GAIN_W;
    localparam int CNT_W    = svm_pkg::CNT_W;
    localparam int MUTE_W   = svm_pkg::MUTE_W;
    localparam int PADDR_W  = svm_pkg::PADDR_W;
    localparam int PDATA_W  = svm_pkg::PDATA_W;

    typedef struct {
        svm_pkg::cmd_e_t     cmd;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   addr;
        logic [SMP_W-1:0]    smp_l;
        logic [SMP_W-1:0]    smp_r;
        logic [FRAMES_W-1:0] frames;
        logic                loop;
        logic [BUS_W-1:0]    bus;
        logic [STEP_W-1:0]   step;
        logic [GAIN_W-1:0]   gain_l;
        logic [GAIN_W-1:0]   gain_r;
    } mix_item_t;

    typedef struct {
        logic              frame_valid;
        logic [SMP_W-1:0]  out_l;
        logic [SMP_W-1:0]  out_r;
        logic [CNT_W-1:0]  active;
        logic              playing;
    } mix_frame_t;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // DUT ports; the inputs are all known from time zero
    logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_command = '0;
    logic [SLOT_W-1:0]         s_voice_slot = '0;
    logic [ADDR_W-1:0]         s_address = '0;
    logic signed [SMP_W-1:0]   s_sample_left = '0, s_sample_right = '0;
    logic [FRAMES_W-1:0]       s_clip_frames = '0;
    logic                      s_looping = 1'b0;
    logic [BUS_W-1:0]          s_bus = '0;
    logic [STEP_W-1:0]         s_step = '0;
    logic [GAIN_W-1:0]         s_gain_left = '0, s_gain_right = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_frame_valid;
    logic signed [SMP_W-1:0]   m_out_left, m_out_right;
    logic [CNT_W-1:0]          m_active_count;
    logic                      m_slot_playing;

    sample_voice_mixer_core dut (.*);

    // mixer model state
    logic [31:0]          smp_store [NWORD];
    bit                   smp_loaded [NWORD];
    logic [2:0]           vflags [NSLOT];   // bit0 active, bit1 paused, bit2 loop
    logic [ADDR_W-1:0]    vbase [NSLOT];
    logic [FRAMES_W-1:0]  vlen [NSLOT];
    logic [31:0]          vcursor [NSLOT];
    logic [STEP_W-1:0]    vstep [NSLOT];
    logic [GAIN_W-1:0]    vgain_l [NSLOT], vgain_r [NSLOT];
    logic [BUS_W-1:0]     vbus [NSLOT];
    logic [15:0]          bus_level [4];    // bus 0 level doubles as master
    logic [MUTE_W-1:0]    mute_bits;
    int                   tanh_tab [NCLIP];

    mix_item_t  pend_items [$];
    mix_frame_t pend_frames [$];
    mix_frame_t frames_due [$];   // expectations for accepted items, oldest first
    mix_frame_t in_flight;
    int         fails = 0;
    int         item_total = 0;
    int         tx_gap = 0, rx_stall = 0;
    bit         tx_burst = 0, rx_burst = 0;

    // mostly short gaps, a few long ones; bursts give stretches with none
    function automatic int pick_gap(ref bit burst);
        int r;
        if ($urandom_range(0, 99) < 3) burst = !burst;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint tanh_clip(longint acc);
        longint mag, k;
        if (acc <= 32767 && acc >= -32768) return acc;
        mag = acc < 0 ? -acc : acc;
        k = (mag - 32768) >>> 11;
        if (k > NCLIP - 1) k = NCLIP - 1;
        return acc < 0 ? -longint'(tanh_tab[k]) : longint'(tanh_tab[k]);
    endfunction

    function automatic longint lerp(longint s0, longint s1, longint frac);
        return s0 + ((frac * (s1 - s0)) >>> 16);
    endfunction

    function automatic longint apply_gain(longint s, longint g);
        return (s * g + 16384) >>> 15;
    endfunction

    function automatic longint bus_level_of(logic [BUS_W-1:0] b);
        return mute_bits[b] ? 0 : longint'(bus_level[b]);
    endfunction

    // frame index pair a render would read for voice v; false if nothing read
    function automatic bit frames_read(int v, output longint ip, output longint nx,
                                       output longint cur);
        longint len;
        len = longint'(vlen[v]);
        cur = longint'(vcursor[v]);
        ip = 0;
        nx = 0;
        if (!vflags[v][0] || vflags[v][1] || len == 0) return 0;
        if ((cur >> 16) >= len) begin
            if (!vflags[v][2]) return 0;
            cur = cur % (len << 16);
        end
        ip = cur >> 16;
        nx = ip + 1;
        if (nx >= len) nx = vflags[v][2] ? 0 : ip;
        return 1;
    endfunction

    function automatic void mix_frame(output longint acc_l, output longint acc_r);
        longint master, ip, nx, cur, bg, gl, gr, frac;
        logic [31:0] w0, w1;
        master = mute_bits[0] ? 0 : longint'(bus_level[0]);
        acc_l = 0;
        acc_r = 0;
        for (int v = 0; v < NSLOT; v++) begin
            if (!vflags[v][0] || vflags[v][1]) continue;
            if (!frames_read(v, ip, nx, cur)) begin
                vflags[v][0] = 1'b0;   // empty clip or one-shot past its end
                continue;
            end
            frac = cur & 64'hFFFF;
            w0 = smp_store[(longint'(vbase[v]) + ip) % NWORD];
            w1 = smp_store[(longint'(vbase[v]) + nx) % NWORD];
            bg = bus_level_of(vbus[v]);
            gl = (longint'(vgain_l[v]) * bg + 16384) >> 15;
            gl = (gl * master + 16384) >> 15;
            gr = (longint'(vgain_r[v]) * bg + 16384) >> 15;
            gr = (gr * master + 16384) >> 15;
            acc_l += apply_gain(lerp(longint'($signed(w0[31:16])),
                                     longint'($signed(w1[31:16])), frac), gl);
            acc_r += apply_gain(lerp(longint'($signed(w0[15:0])),
                                     longint'($signed(w1[15:0])), frac), gr);
            vcursor[v] = 32'(cur + longint'(vstep[v]));
        end
    endfunction

    function automatic mix_frame_t predict(mix_item_t it);
        mix_frame_t f;
        longint acc_l, acc_r;
        int s, n;
        s = int'(it.slot);
        f = '{default: '0};
        case (it.cmd)
            svm_pkg::CMD_LOAD: begin
                smp_store[it.addr] = {it.smp_l, it.smp_r};
                smp_loaded[it.addr] = 1;
            end
            svm_pkg::CMD_START: begin
                vbase[s] = it.addr;
                vlen[s] = it.frames;
                vcursor[s] = '0;
                vstep[s] = it.step;
                vgain_l[s] = it.gain_l;
                vgain_r[s] = it.gain_r;
                vbus[s] = it.bus;
                vflags[s] = {it.loop, 2'b01};
            end
            svm_pkg::CMD_STOP:     vflags[s][0] = 1'b0;
            svm_pkg::CMD_PAUSE:    vflags[s][1] = 1'b1;
            svm_pkg::CMD_RESUME:   vflags[s][1] = 1'b0;
            svm_pkg::CMD_STOP_ALL: for (int v = 0; v < NSLOT; v++) vflags[v][0] = 1'b0;
            svm_pkg::CMD_RENDER: begin
                mix_frame(acc_l, acc_r);
                f.frame_valid = 1'b1;
                f.out_l = SMP_W'(tanh_clip(acc_l));
                f.out_r = SMP_W'(tanh_clip(acc_r));
            end
            default: begin   // update: flags other than loop untouched, even on a free slot
                vstep[s] = it.step;
                vgain_l[s] = it.gain_l;
                vgain_r[s] = it.gain_r;
                vbus[s] = it.bus;
                vflags[s][2] = it.loop;
            end
        endcase
        n = 0;
        for (int v = 0; v < NSLOT; v++) n += int'(vflags[v][0]);
        f.active = CNT_W'(n);
        f.playing = vflags[s][0] && !vflags[s][1];
        return f;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(0, 32768));
        if (r < 90) return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 2))
            0: return 16'd0;
            1: return svm_pkg::GAIN_UNITY;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic mix_item_t rand_fields(svm_pkg::cmd_e_t c);
        mix_item_t it;
        int r;
        it.cmd = c;
        it.slot = SLOT_W'($urandom_range(0, NSLOT - 1));
        it.addr = ADDR_W'($urandom_range(0, NWORD - 1));
        it.smp_l = rand_sample();
        it.smp_r = rand_sample();
        r = $urandom_range(0, 99);
        if (r < 70) it.frames = FRAMES_W'($urandom_range(1, 64));
        else if (r < 90) it.frames = FRAMES_W'($urandom_range(0, 512));
        else if (r < 97) it.frames = FRAMES_W'($urandom_range(0, 32767));
        else it.frames = 15'd16384;
        it.loop = 1'($urandom_range(0, 1));
        it.bus = BUS_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 60) it.step = STEP_W'($urandom_range(0, 32'h20000));
        else if (r < 90) it.step = STEP_W'($urandom_range(0, 32'h7FFFF));
        else it.step = ($urandom_range(0, 1) != 0) ? 19'h7FFFF : 19'h10000;
        it.gain_l = rand_gain();
        it.gain_r = rand_gain();
        return it;
    endfunction

    task automatic queue_item(mix_item_t it);
        pend_items = {pend_items, it};
        pend_frames = {pend_frames, predict(it)};
        item_total++;
    endtask

    // a render may only read words already loaded: fill any gap first
    task automatic queue_cmd(mix_item_t it);
        longint ip, nx, cur, adr;
        mix_item_t ld;
        if (it.cmd == svm_pkg::CMD_RENDER) begin
            for (int v = 0; v < NSLOT; v++) begin
                if (!frames_read(v, ip, nx, cur)) continue;
                for (int k = 0; k < 2; k++) begin
                    adr = (longint'(vbase[v]) + (k == 0 ? ip : nx)) % NWORD;
                    if (!smp_loaded[adr]) begin
                        ld = rand_fields(svm_pkg::CMD_LOAD);
                        ld.addr = ADDR_W'(adr);
                        queue_item(ld);
                    end
                end
            end
        end
        queue_item(it);
    endtask

    task automatic directed(svm_pkg::cmd_e_t c, int slot, int addr, int frames, bit loop,
                            int step, int gl, int gr);
        mix_item_t it;
        it = rand_fields(c);
        it.slot = SLOT_W'(slot);
        it.addr = ADDR_W'(addr);
        it.frames = FRAMES_W'(frames);
        it.loop = loop;
        it.step = STEP_W'(step);
        it.gain_l = GAIN_W'(gl);
        it.gain_r = GAIN_W'(gr);
        queue_cmd(it);
    endtask

    // mostly playback traffic with random content, a share of odd commands
    task automatic random_cmd();
        int r;
        svm_pkg::cmd_e_t c;
        r = $urandom_range(0, 99);
        if (r < 35) c = svm_pkg::CMD_RENDER;
        else if (r < 52) c = svm_pkg::CMD_START;
        else if (r < 64) c = svm_pkg::CMD_LOAD;
        else if (r < 72) c = svm_pkg::CMD_UPDATE;
        else if (r < 79) c = svm_pkg::CMD_PAUSE;
        else if (r < 86) c = svm_pkg::CMD_RESUME;
        else if (r < 97) c = svm_pkg::CMD_STOP;
        else c = svm_pkg::CMD_STOP_ALL;
        queue_cmd(rand_fields(c));
    endtask

    // sender paused until every outstanding result item has been checked
    task automatic drain();
        do @(negedge aclk);
        while (pend_items.size() != 0 || s_valid || frames_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(svm_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);   // write lands on this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == svm_pkg::REG_MUTE) mute_bits = val[MUTE_W-1:0];
        else bus_level[idx] = val[15:0];
    endtask

    task automatic set_levels(int m, int sfx, int mus, int sp, int mute);
        write_reg(svm_pkg::REG_MASTER, 32'(m));
        write_reg(svm_pkg::REG_SFX, 32'(sfx));
        write_reg(svm_pkg::REG_MUSIC, 32'(mus));
        write_reg(svm_pkg::REG_SPEECH, 32'(sp));
        write_reg(svm_pkg::REG_MUTE, 32'(mute));
    endtask

    // item driver: valid holds with its payload until the handshake
    always @(posedge aclk) begin
        mix_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) frames_due = {frames_due, in_flight};
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pend_items.size() != 0) begin
                it = pend_items.pop_front();
                in_flight <= pend_frames.pop_front();
                s_command <= it.cmd;
                s_voice_slot <= it.slot;
                s_address <= it.addr;
                s_sample_left <= it.smp_l;
                s_sample_right <= it.smp_r;
                s_clip_frames <= it.frames;
                s_looping <= it.loop;
                s_bus <= it.bus;
                s_step <= it.step;
                s_gain_left <= it.gain_l;
                s_gain_right <= it.gain_r;
                s_valid <= 1'b1;
                tx_gap <= pick_gap(tx_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        mix_frame_t want;
        int g;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $error("result item with no expectation waiting");
                fails++;
            end else begin
                want = frames_due.pop_front();
                if (m_frame_valid !== want.frame_valid) begin
                    $error("frame_valid expected %0d got %0d", want.frame_valid, m_frame_valid);
                    fails++;
                end
                if (m_out_left !== want.out_l) begin
                    $error("out_left expected %0d got %0d", $signed(want.out_l), m_out_left);
                    fails++;
                end
                if (m_out_right !== want.out_r) begin
                    $error("out_right expected %0d got %0d", $signed(want.out_r), m_out_right);
                    fails++;
                end
                if (m_active_count !== want.active) begin
                    $error("active_count expected %0d got %0d", want.active, m_active_count);
                    fails++;
                end
                if (m_slot_playing !== want.playing) begin
                    $error("slot_playing expected %0d got %0d", want.playing, m_slot_playing);
                    fails++;
                end
            end
            g = pick_gap(rx_burst);
            rx_stall <= g > 0 ? g - 1 : 0;
            m_ready <= (g == 0);
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        longint unsigned p, t;
        // tanh(1 + k/16) table from repeated Q30 products of exp(-1/8)
        p = Q30_ONE;
        for (int i = 0; i < 16; i++) p = (p * Q30_DECAY + (Q30_ONE >> 1)) >> 30;
        for (int i = 0; i < NCLIP; i++) begin
            t = ((Q30_ONE - p) * 32768 + ((Q30_ONE + p) >> 1)) / (Q30_ONE + p);
            tanh_tab[i] = t > 32767 ? 32767 : int'(t);
            p = (p * Q30_DECAY + (Q30_ONE >> 1)) >> 30;
        end
        for (int v = 0; v < NSLOT; v++) begin
            vflags[v] = '0;
            vbase[v] = '0;
            vlen[v] = '0;
            vcursor[v] = '0;
            vstep[v] = '0;
            vgain_l[v] = '0;
            vgain_r[v] = '0;
            vbus[v] = '0;
        end
        for (int b = 0; b < 4; b++) bus_level[b] = svm_pkg::GAIN_UNITY;
        mute_bits = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wrap at the top of memory, full-scale gains and steps
        directed(svm_pkg::CMD_START, 0, NWORD - 1, 2, 1, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
        directed(svm_pkg::CMD_START, 1, 0, 3, 0, 19'h08000, 32768, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        // zero-length clip finishes at its first render
        directed(svm_pkg::CMD_START, 31, 5, 0, 1, 19'h10000, 32768, 32768);
        directed(svm_pkg::CMD_RENDER, 31, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_PAUSE, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RESUME, 0, 0, 1, 0, 0, 0, 0);
        // pause, resume and update on a slot never started leave it free
        directed(svm_pkg::CMD_PAUSE, 7, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RESUME, 7, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_UPDATE, 7, 0, 1, 1, 19'h7FFFF, 65535, 65535);
        // update flips the loop flag of a playing voice
        directed(svm_pkg::CMD_UPDATE, 1, 0, 1, 1, 19'h18000, 40000, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        // restart on a busy slot rewinds the cursor
        directed(svm_pkg::CMD_START, 0, 100, 16384, 0, 19'h7FFFF, 65535, 65535);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_STOP, 1, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_START, 2, 16380, 32767, 1, 0, 0, 0);
        directed(svm_pkg::CMD_STOP_ALL, 0, 0, 1, 0, 0, 0, 0);
        directed(svm_pkg::CMD_RENDER, 0, 0, 1, 0, 0, 0, 0);
        drain();

        // random phases across level settings, extremes first; sample loads
        // a render needs count towards the item budget
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_levels(32768, 32768, 32768, 32768, 0);
                1: set_levels(0, 0, 0, 0, 15);
                2: set_levels(32768, 0, 32768, 0, 10);
                3: set_levels($urandom_range(0, 32768), $urandom_range(0, 32768),
                              $urandom_range(0, 32768), $urandom_range(0, 32768),
                              $urandom_range(0, 15));
                default: set_levels(32768, $urandom_range(0, 32768), 32768,
                                    $urandom_range(0, 32768), 1);
            endcase
            while (item_total < ITEM_TARGET * (ph + 1) / 5) random_cmd();
            drain();
        end

        repeat (50) @(negedge aclk);
        if (fails == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sample_voice_mixer_core.f
hdl/svm_pkg.sv
hdl/svm_ctrl.sv
hdl/svm_datapath.sv
hdl/sample_voice_mixer_core.sv
hdl/svm_checker.sv
tb/sv/tb_top.sv
